// ----- rtl/stop_line_crossing_qualifier_unit_assert.svh -----
// Assertion macros for the stop line crossing qualifier
`ifndef STOP_LINE_CROSSING_QUALIFIER_UNIT_ASSERT_SVH
`define STOP_LINE_CROSSING_QUALIFIER_UNIT_ASSERT_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define SLCQ_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SLCQ_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/slcq_pkg.sv -----
// Types and constants shared by the stop line crossing qualifier
package slcq_pkg;

	localparam int OP_W     = 2;
	localparam int FRAC_W   = 8;
	localparam int HEIGHT_W = 11;
	localparam int RUN_W    = 8;
	localparam int CNT_W    = 4;
	localparam int TICK_W   = 16;
	localparam int PROD_W   = FRAC_W + HEIGHT_W;
	localparam int ADDR_W   = 5;
	localparam int DATA_W   = 32;
	localparam int OUT_W    = 8;

	localparam logic [FRAC_W-1:0]   CROSS_FRACTION_RST = 8'd205;
	localparam logic [HEIGHT_W-1:0] FRAME_HEIGHT_RST   = 11'd240;
	localparam logic [RUN_W-1:0]    FAR_FRAMES_RST     = 8'd3;
	localparam logic [RUN_W-1:0]    NEAR_FRAMES_RST    = 8'd3;
	localparam logic [RUN_W-1:0]    MISS_FRAMES_RST    = 8'd3;
	localparam logic [CNT_W-1:0]    LINE_TARGET_RST    = 4'd2;
	localparam logic [TICK_W-1:0]   HOLD_TICKS_RST     = 16'd3000;

	localparam logic [RUN_W-1:0]  RUN_MAX  = '1;
	localparam logic [CNT_W-1:0]  CNT_MAX  = '1;
	localparam logic [TICK_W-1:0] TICK_MAX = '1;

	typedef enum logic [OP_W-1:0] {
		OP_FRAME = 2'd0,
		OP_TICK  = 2'd1,
		OP_CLEAR = 2'd2
	} slcq_op_t;

	typedef enum logic [2:0] {
		REG_CROSS_FRACTION = 3'd0,
		REG_FRAME_HEIGHT   = 3'd1,
		REG_FAR_FRAMES     = 3'd2,
		REG_NEAR_FRAMES    = 3'd3,
		REG_MISS_FRAMES    = 3'd4,
		REG_LINE_TARGET    = 3'd5,
		REG_HOLD_TICKS     = 3'd6
	} slcq_reg_t;

	typedef struct packed {
		logic [FRAC_W-1:0]   cross_fraction;
		logic [HEIGHT_W-1:0] frame_height;
		logic [RUN_W-1:0]    far_frames;
		logic [RUN_W-1:0]    near_frames;
		logic [RUN_W-1:0]    miss_frames;
		logic [CNT_W-1:0]    line_target;
		logic [TICK_W-1:0]   hold_ticks;
	} slcq_cfg_t;

	typedef struct packed {
		logic             seen_far;
		logic [CNT_W-1:0] crossings;
		logic             just_entered;
		logic             holding;
	} slcq_res_t;

endpackage

// ----- rtl/slcq_cfg_regs.sv -----
// APB configuration registers of the stop line crossing qualifier
module slcq_cfg_regs
	import slcq_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output slcq_cfg_t         cfg
);

	slcq_cfg_t cfg_q;
	slcq_reg_t reg_idx;
	logic      wr_en;

	assign pready  = 1'b1;
	assign reg_idx = slcq_reg_t'(paddr[ADDR_W-1:2]);
	assign wr_en   = psel & penable & pwrite & pready;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cross_fraction <= CROSS_FRACTION_RST;
			cfg_q.frame_height   <= FRAME_HEIGHT_RST;
			cfg_q.far_frames     <= FAR_FRAMES_RST;
			cfg_q.near_frames    <= NEAR_FRAMES_RST;
			cfg_q.miss_frames    <= MISS_FRAMES_RST;
			cfg_q.line_target    <= LINE_TARGET_RST;
			cfg_q.hold_ticks     <= HOLD_TICKS_RST;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_CROSS_FRACTION: cfg_q.cross_fraction <= pwdata[FRAC_W-1:0];
				REG_FRAME_HEIGHT:   cfg_q.frame_height   <= pwdata[HEIGHT_W-1:0];
				REG_FAR_FRAMES:     cfg_q.far_frames     <= pwdata[RUN_W-1:0];
				REG_NEAR_FRAMES:    cfg_q.near_frames    <= pwdata[RUN_W-1:0];
				REG_MISS_FRAMES:    cfg_q.miss_frames    <= pwdata[RUN_W-1:0];
				REG_LINE_TARGET:    cfg_q.line_target    <= pwdata[CNT_W-1:0];
				REG_HOLD_TICKS:     cfg_q.hold_ticks     <= pwdata[TICK_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (reg_idx)
			REG_CROSS_FRACTION: prdata = DATA_W'(cfg_q.cross_fraction);
			REG_FRAME_HEIGHT:   prdata = DATA_W'(cfg_q.frame_height);
			REG_FAR_FRAMES:     prdata = DATA_W'(cfg_q.far_frames);
			REG_NEAR_FRAMES:    prdata = DATA_W'(cfg_q.near_frames);
			REG_MISS_FRAMES:    prdata = DATA_W'(cfg_q.miss_frames);
			REG_LINE_TARGET:    prdata = DATA_W'(cfg_q.line_target);
			REG_HOLD_TICKS:     prdata = DATA_W'(cfg_q.hold_ticks);
			default:            prdata = '0;
		endcase
	end

endmodule

// ----- rtl/slcq_core.sv -----
// Qualifier state and its registered update for one item
module slcq_core
	import slcq_pkg::*;
#(
	parameter int ROW_BITS = 10
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                upd,
	input  slcq_op_t            op,
	input  logic                det,
	input  logic [ROW_BITS-1:0] row,
	input  slcq_cfg_t           cfg,
	output slcq_res_t           res
);

	localparam int CMP_W = (ROW_BITS > HEIGHT_W) ? ROW_BITS : HEIGHT_W;

	logic [RUN_W-1:0]  far_run_q, near_run_q, miss_run_q;
	logic              phase_far_q;
	logic [CNT_W-1:0]  crossing_q;
	logic              hold_q;
	logic [TICK_W-1:0] elapsed_q;

	logic [RUN_W-1:0]  far_run_n, near_run_n, miss_run_n;
	logic              phase_far_n;
	logic [CNT_W-1:0]  crossing_n;
	logic              hold_n;
	logic [TICK_W-1:0] elapsed_n;
	logic              entered;

	logic [PROD_W-1:0]   prod;
	logic [HEIGHT_W-1:0] cross_row;
	logic                row_ok;
	logic                row_far;

	assign prod      = PROD_W'(cfg.cross_fraction) * PROD_W'(cfg.frame_height);
	assign cross_row = prod[PROD_W-1:FRAC_W];
	assign row_ok    = det && (CMP_W'(row) < CMP_W'(cfg.frame_height));
	assign row_far   = CMP_W'(row) < CMP_W'(cross_row);

	always_comb begin
		far_run_n   = far_run_q;
		near_run_n  = near_run_q;
		miss_run_n  = miss_run_q;
		phase_far_n = phase_far_q;
		crossing_n  = crossing_q;
		hold_n      = hold_q;
		elapsed_n   = elapsed_q;
		entered     = 1'b0;
		case (op)
			OP_FRAME: begin
				if (cfg.frame_height != '0) begin
					if (row_ok) begin
						miss_run_n = '0;
						if (row_far) begin
							far_run_n  = (far_run_q == RUN_MAX) ? RUN_MAX : far_run_q + 1'b1;
							near_run_n = '0;
							if (far_run_n >= cfg.far_frames)
								phase_far_n = 1'b1;
						end else begin
							near_run_n = (near_run_q == RUN_MAX) ? RUN_MAX : near_run_q + 1'b1;
							if (phase_far_q && near_run_n >= cfg.near_frames) begin
								crossing_n  = (crossing_q == CNT_MAX) ? CNT_MAX
									: crossing_q + 1'b1;
								phase_far_n = 1'b0;
								far_run_n   = '0;
								near_run_n  = '0;
							end
						end
					end else begin
						far_run_n  = '0;
						near_run_n = '0;
						miss_run_n = (miss_run_q == RUN_MAX) ? RUN_MAX : miss_run_q + 1'b1;
						if (miss_run_n >= cfg.miss_frames)
							phase_far_n = 1'b0;
					end
					if (!hold_q && crossing_n >= cfg.line_target) begin
						hold_n    = 1'b1;
						elapsed_n = '0;
						entered   = 1'b1;
					end
				end
			end
			OP_TICK: begin
				if (hold_q) begin
					elapsed_n = (elapsed_q == TICK_MAX) ? TICK_MAX : elapsed_q + 1'b1;
					if (elapsed_n >= cfg.hold_ticks) begin
						far_run_n   = '0;
						near_run_n  = '0;
						miss_run_n  = '0;
						phase_far_n = 1'b0;
						crossing_n  = '0;
						hold_n      = 1'b0;
						elapsed_n   = '0;
					end
				end
			end
			OP_CLEAR: begin
				far_run_n   = '0;
				near_run_n  = '0;
				miss_run_n  = '0;
				phase_far_n = 1'b0;
				crossing_n  = '0;
				hold_n      = 1'b0;
				elapsed_n   = '0;
			end
			default: ;
		endcase
	end

	assign res.holding      = hold_n;
	assign res.just_entered = entered;
	assign res.crossings    = crossing_n;
	assign res.seen_far     = phase_far_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			far_run_q   <= '0;
			near_run_q  <= '0;
			miss_run_q  <= '0;
			phase_far_q <= 1'b0;
			crossing_q  <= '0;
			hold_q      <= 1'b0;
			elapsed_q   <= '0;
		end else if (upd) begin
			far_run_q   <= far_run_n;
			near_run_q  <= near_run_n;
			miss_run_q  <= miss_run_n;
			phase_far_q <= phase_far_n;
			crossing_q  <= crossing_n;
			hold_q      <= hold_n;
			elapsed_q   <= elapsed_n;
		end
	end

endmodule

// ----- rtl/stop_line_crossing_qualifier_unit.sv -----
// Top level of the stop line crossing qualifier
//
//  channel   | dir | payload
//  ----------+-----+-----------------------------------------------------
//  s_axis    | in  | tuser: operation; tdata: detected, line_row
//  m_axis    | out | tdata: holding, just_entered, crossings, seen_far
//  apb       | in  | seven registers at byte address 4*i
//
//  One item per clock sustained while m_axis is not stalled; m_axis_tvalid rises
//  once an accepted item has passed the input register and then the state update
//  into the result register.
//  arst_n clears the detection state, the valid flags and the registers to defaults.
//  A stall on m_axis holds the result register and the input register; a new
//  item is still taken while the result waits if the input register is free.

`include "stop_line_crossing_qualifier_unit_assert.svh"

module stop_line_crossing_qualifier_unit
	import slcq_pkg::*;
#(
	parameter int ROW_BITS = 10,
	localparam int IN_W = ((ROW_BITS + 1 + 7) / 8) * 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	input  logic [IN_W-1:0]   s_axis_tdata,   // [0] detected, [ROW_BITS:1] line_row
	input  logic [OP_W-1:0]   s_axis_tuser,   // [1:0] operation
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	output logic [OUT_W-1:0]  m_axis_tdata,   // [0] holding, [1] just_entered,
	                                          // [5:2] crossings, [6] seen_far
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready
);

	slcq_cfg_t           cfg;
	slcq_res_t           res_nxt;
	slcq_res_t           res_s2;
	logic                valid_s1, valid_s2;
	slcq_op_t            op_s1;
	logic                det_s1;
	logic [ROW_BITS-1:0] row_s1;
	logic                adv, upd, in_fire;

	assign adv           = !valid_s2 || m_axis_tready;
	assign upd           = valid_s1 && adv;
	assign s_axis_tready = !valid_s1 || adv;
	assign in_fire       = s_axis_tvalid && s_axis_tready;
	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {1'b0, res_s2.seen_far, res_s2.crossings,
		res_s2.just_entered, res_s2.holding};

	slcq_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	slcq_core #(
		.ROW_BITS (ROW_BITS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.upd    (upd),
		.op     (op_s1),
		.det    (det_s1),
		.row    (row_s1),
		.cfg    (cfg),
		.res    (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_fire)
				valid_s1 <= 1'b1;
			else if (upd)
				valid_s1 <= 1'b0;
			if (adv)
				valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			op_s1  <= slcq_op_t'(s_axis_tuser);
			det_s1 <= s_axis_tdata[0];
			row_s1 <= s_axis_tdata[ROW_BITS:1];
		end
		if (upd)
			res_s2 <= res_nxt;
	end

	`SLCQ_ASSERT_NOW(a_ready_when_empty, !valid_s2, s_axis_tready,
		"input stalled with empty result register")
	`SLCQ_ASSERT_NEXT(a_entry_holds, upd && res_nxt.just_entered,
		valid_s2 && res_s2.holding, "hold entry not reported as holding")
	`SLCQ_ASSERT_NEXT(a_clear_zeroes, upd && op_s1 == OP_CLEAR,
		valid_s2 && res_s2.crossings == '0 && !res_s2.seen_far && !res_s2.holding,
		"clear item left state behind")

endmodule
